FILE: rtl/sdh_pkg.sv
// Shared types and codes for the read-depth coverage histogram.
package sdh_pkg;

  localparam int DEPTH_W  = 32;
  localparam int COUNT_W  = 48;
  localparam int WEIGHT_W = 16;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_END  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LONG   = 2'd1;
  localparam logic [1:0] ST_BEHIND = 2'd2;

  // Control broadcast to every window cell.
  typedef struct packed {
    logic                shift;
    logic                add;
    logic [WEIGHT_W-1:0] weight;
  } cell_ctrl_t;

endpackage

FILE: rtl/sdh_cell.sv
// One window cell: holds the depth of one position and hands it to its neighbor on a slide.
module sdh_cell
  import sdh_pkg::*;
#(
  parameter int AW    = 11,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  cell_ctrl_t         ctrl,
  input  logic [AW-1:0]      first,
  input  logic [AW-1:0]      last,
  input  logic [DEPTH_W-1:0] shift_in,
  output logic [DEPTH_W-1:0] depth
);

  localparam logic [AW-1:0] MY_POS = AW'(INDEX);

  logic [DEPTH_W:0]   sum;
  logic               in_range;
  logic [DEPTH_W-1:0] depth_next;

  // Saturating add when this position lies inside the broadcast range.
  always_comb begin
    sum        = {1'b0, depth} + (DEPTH_W + 1)'(ctrl.weight);
    in_range   = (MY_POS >= first) && (MY_POS <= last);
    depth_next = depth;
    if (ctrl.shift) begin
      depth_next = shift_in;
    end else if (ctrl.add && in_range) begin
      depth_next = sum[DEPTH_W] ? '1 : sum[DEPTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else begin
      depth <= depth_next;
    end
  end

endmodule

FILE: rtl/sdh_hist.sv
// Histogram bin memory with one registered read port and one write port.
module sdh_hist
  import sdh_pkg::*;
#(
  parameter int DEPTH_BINS = 256,
  parameter int BW         = 8
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [BW-1:0]      rd_addr,
  output logic [COUNT_W-1:0] rd_data,
  input  logic               wr_en,
  input  logic [BW-1:0]      wr_addr,
  input  logic [COUNT_W-1:0] wr_data
);

  logic [COUNT_W-1:0] mem [DEPTH_BINS];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/sequencing_depth_histogram_top.sv
// Top level of the read-depth coverage histogram.
//
// Input channel (in_valid/in_stall): one item per request: add an interval,
// end a subject, or read one histogram bin. Output channel (out_valid/
// out_stall): exactly one result item per input item, in order. The single
// register count_repeats is written through cfg_valid/cfg_ready; the user must
// write it only while the block is idle, which the block does not enforce.
// From acceptance, a rejected or unknown request passes through S_DECODE to
// S_RESP; a bin read or an interval add inside the window passes through
// S_DECODE and then S_READ or S_ADD before S_RESP. The input is free again
// in the same cycle as the result appears. An add that slides the window first
// steps each flushed position through S_FLUSH, with a read-modify-write of its
// bin via S_FL_WR for a position with nonzero depth, and then adds in S_ADD.
// End of subject flushes the whole window the same way and then updates bin 0
// through S_B0_RD and S_B0_WR.
// The window itself is a row of WINDOW_LEN cells that shift toward cell 0;
// the histogram is a memory with one read and one write port.
// After reset the block clears the histogram memory, one bin per cycle, and
// holds in_stall high meanwhile.
// A new item is taken while a finished result still waits; when the receiver
// stalls, the held result stays stable and the following result waits.
module sequencing_depth_histogram_top
  import sdh_pkg::*;
#(
  parameter int WINDOW_LEN = 2048,
  parameter int DEPTH_BINS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic [31:0]         start_pos,
  input  logic [31:0]         end_pos,
  input  logic [15:0]         repeat_count,
  input  logic [31:0]         subject_length,
  input  logic [7:0]          bin_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [COUNT_W-1:0]  bin_count,
  output logic [COUNT_W-1:0]  base_sum,
  output logic [COUNT_W-1:0]  aligned_reads
);

  localparam int AW = $clog2(WINDOW_LEN);
  localparam int CW = $clog2(WINDOW_LEN + 1);
  localparam int BW = $clog2(DEPTH_BINS);
  localparam logic [BW-1:0] LAST_BIN = BW'(DEPTH_BINS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_FLUSH, S_FL_WR, S_ADD,
    S_B0_RD, S_B0_WR, S_READ, S_RESP
  } state_t;

  state_t state;

  // Item and architectural registers.
  logic [1:0]          req;
  logic [31:0]         start_q, end_q, len_q;
  logic [15:0]         rpt_q;
  logic [7:0]          bin_q;
  logic                count_repeats;
  logic [31:0]         window_base;
  logic [31:0]         hit_positions;
  logic [COUNT_W-1:0]  base_total, read_total;
  logic [COUNT_W-1:0]  count_q;
  logic [1:0]          status_q;
  logic [CW-1:0]       flush_cnt;
  logic [BW-1:0]       clr_cnt;
  logic [BW-1:0]       flush_bin;

  // Window cells.
  cell_ctrl_t          ctrl;
  logic [AW-1:0]       first, last;
  logic [DEPTH_W-1:0]  depths [WINDOW_LEN];

  // Histogram memory ports.
  logic                h_rd_en, h_wr_en;
  logic [BW-1:0]       h_rd_addr, h_wr_addr;
  logic [COUNT_W-1:0]  h_rd_data, h_wr_data;

  // Decode helpers.
  logic [15:0]         weight;
  logic [32:0]         win_end;
  logic [31:0]         span, shift_amt, first_off, last_off;
  logic                behind, too_long, slides, bin_ok;
  logic [16:0]         bin_wide;
  logic [DEPTH_W-1:0]  head;
  logic [BW-1:0]       head_bin;
  logic                resp_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign resp_fire = (state == S_RESP) && (!out_valid || !out_stall);

  always_comb begin
    weight    = count_repeats ? rpt_q : 16'd1;
    win_end   = {1'b0, window_base} + 33'(WINDOW_LEN);
    span      = end_q - start_q;
    behind    = start_q < window_base;
    too_long  = (end_q < start_q) || (span >= 32'(WINDOW_LEN));
    slides    = {1'b0, end_q} >= win_end;
    shift_amt = ({1'b0, start_q} < win_end) ? (start_q - window_base) : 32'(WINDOW_LEN);
    first_off = start_q - window_base;
    last_off  = end_q - window_base;
    bin_wide  = 17'(bin_q);
    bin_ok    = {24'd0, bin_q} < 32'(DEPTH_BINS);
    head      = depths[0];
    head_bin  = (head >= 32'(DEPTH_BINS - 1)) ? LAST_BIN : head[BW-1:0];
  end

  // Cell control and memory port selection.
  always_comb begin
    ctrl.shift  = 1'b0;
    ctrl.add    = (state == S_ADD);
    ctrl.weight = weight;
    first       = first_off[AW-1:0];
    last        = last_off[AW-1:0];
    h_rd_en     = 1'b0;
    h_rd_addr   = head_bin;
    h_wr_en     = 1'b0;
    h_wr_addr   = flush_bin;
    h_wr_data   = h_rd_data + COUNT_W'(1);
    case (state)
      S_CLEAR: begin
        h_wr_en   = 1'b1;
        h_wr_addr = clr_cnt;
        h_wr_data = '0;
      end
      S_DECODE: begin
        h_rd_en   = (req == REQ_READ);
        h_rd_addr = bin_wide[BW-1:0];
      end
      S_FLUSH: begin
        if (flush_cnt != '0) begin
          ctrl.shift = (head == '0);
          h_rd_en    = (head != '0);
        end
      end
      S_FL_WR: begin
        ctrl.shift = 1'b1;
        h_wr_en    = 1'b1;
      end
      S_B0_RD: begin
        h_rd_en   = 1'b1;
        h_rd_addr = '0;
      end
      S_B0_WR: begin
        h_wr_en   = len_q > hit_positions;
        h_wr_addr = '0;
        h_wr_data = h_rd_data + COUNT_W'(len_q - hit_positions);
      end
      default: begin
      end
    endcase
  end

  // Row of cells; the last one takes in zeros on a slide.
  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    logic [DEPTH_W-1:0] nb;
    if (i == WINDOW_LEN - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = depths[i+1];
    end
    sdh_cell #(.AW(AW), .INDEX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .first    (first),
      .last     (last),
      .shift_in (nb),
      .depth    (depths[i])
    );
  end

  sdh_hist #(.DEPTH_BINS(DEPTH_BINS), .BW(BW)) u_hist (
    .clk     (clk),
    .rd_en   (h_rd_en),
    .rd_addr (h_rd_addr),
    .rd_data (h_rd_data),
    .wr_en   (h_wr_en),
    .wr_addr (h_wr_addr),
    .wr_data (h_wr_data)
  );

  // Sequencer, state and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      count_repeats <= 1'b0;
      window_base   <= '0;
      hit_positions <= '0;
      base_total    <= '0;
      read_total    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        count_repeats <= cfg_data;
      end
      if (resp_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + BW'(1);
          if (clr_cnt == LAST_BIN) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req     <= req_type;
            start_q <= start_pos;
            end_q   <= end_pos;
            rpt_q   <= repeat_count;
            len_q   <= subject_length;
            bin_q   <= bin_index;
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          status_q <= ST_OK;
          count_q  <= '0;
          state    <= S_RESP;
          case (req)
            REQ_ADD: begin
              if (behind) begin
                status_q <= ST_BEHIND;
              end else if (too_long) begin
                status_q <= ST_LONG;
              end else begin
                read_total <= read_total + COUNT_W'(weight);
                if (slides) begin
                  flush_cnt <= shift_amt[CW-1:0];
                  state     <= S_FLUSH;
                end else begin
                  state <= S_ADD;
                end
              end
            end
            REQ_END: begin
              flush_cnt <= CW'(WINDOW_LEN);
              state     <= S_FLUSH;
            end
            REQ_READ: begin
              if (bin_ok) begin
                state <= S_READ;
              end
            end
            default: begin
            end
          endcase
        end
        S_FLUSH: begin
          if (flush_cnt == '0) begin
            if (req == REQ_END) begin
              state <= S_B0_RD;
            end else begin
              window_base <= start_q;
              state       <= S_ADD;
            end
          end else if (head == '0) begin
            flush_cnt <= flush_cnt - CW'(1);
          end else begin
            flush_bin <= head_bin;
            state     <= S_FL_WR;
          end
        end
        S_FL_WR: begin
          hit_positions <= hit_positions + 32'd1;
          flush_cnt     <= flush_cnt - CW'(1);
          state         <= S_FLUSH;
        end
        S_ADD: begin
          state <= S_RESP;
        end
        S_B0_RD: begin
          state <= S_B0_WR;
        end
        S_B0_WR: begin
          base_total    <= base_total + COUNT_W'(len_q);
          window_base   <= '0;
          hit_positions <= '0;
          state         <= S_RESP;
        end
        S_READ: begin
          count_q <= h_rd_data;
          state   <= S_RESP;
        end
        S_RESP: begin
          if (resp_fire) begin
            status        <= status_q;
            bin_count     <= count_q;
            base_sum      <= base_total;
            aligned_reads <= read_total;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/sdh_checker.sv
// Port-level checker for the read-depth coverage histogram, bound to the top level.
module sdh_checker
  import sdh_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         status,
  input logic [COUNT_W-1:0] bin_count
);

  // A held result item keeps its bin count.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bin_count))
    else $error("stalled result changed");

  // An accepted item blocks the input for at least the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // A rejected interval never reports a bin count.
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> bin_count == '0)
    else $error("rejected item carries a bin count");

endmodule

bind sequencing_depth_histogram_top sdh_checker u_sdh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .bin_count (bin_count)
);

FILE: dv/tb.sv
// Self-checking testbench for the read-depth coverage histogram block.
module tb;
  import sdh_pkg::*;

  localparam int WIN  = 2048;
  localparam int BINS = 256;
  localparam int CYCLE_LIMIT = 30000000;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct {
    logic [1:0]         status;
    logic [COUNT_W-1:0] bin_count;
    logic [COUNT_W-1:0] base_sum;
    logic [COUNT_W-1:0] aligned_reads;
  } result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid, cfg_ready, cfg_data;
  logic in_valid, in_stall;
  logic [1:0] req_type;
  logic [31:0] start_pos, end_pos, subject_length;
  logic [15:0] repeat_count;
  logic [7:0] bin_index;
  logic out_valid, out_stall;
  logic [1:0] status;
  logic [COUNT_W-1:0] bin_count, base_sum, aligned_reads;

  // Shadow copy of the coverage state.
  logic [31:0]        cov_depth [WIN];
  logic [31:0]        cov_base;
  logic [31:0]        cov_hits;
  logic [COUNT_W-1:0] cov_hist [BINS];
  logic [COUNT_W-1:0] cov_bases;
  logic [COUNT_W-1:0] cov_reads;
  logic               cov_weighted;

  result_t pending_results[$];
  bit      failed = 1'b0;
  bit      calm = 1'b0;
  int      cycles = 0;
  logic [31:0] cursor;

  sequencing_depth_histogram_top DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Flush the first count positions of the window into the histogram.
  function automatic void flush_window(int count);
    int b;
    for (int j = 0; j < count && j < WIN; j++) begin
      if (cov_depth[j] != 0) begin
        b = (cov_depth[j] > BINS - 1) ? BINS - 1 : int'(cov_depth[j]);
        cov_hist[b] = cov_hist[b] + COUNT_W'(1);
        cov_hits = cov_hits + 32'd1;
      end
    end
  endfunction

  function automatic logic [1:0] add_coverage(logic [31:0] s, logic [31:0] e,
                                              logic [31:0] w);
    longint win_end, shift, lo, hi, sum;
    win_end = longint'(cov_base) + longint'(WIN);
    if (s < cov_base) return ST_BEHIND;
    if (e < s || longint'(e) - longint'(s) + 1 > longint'(WIN)) return ST_LONG;
    cov_reads = cov_reads + COUNT_W'(w);
    if (longint'(e) >= win_end) begin
      shift = (longint'(s) < win_end) ? longint'(s - cov_base) : longint'(WIN);
      flush_window(int'(shift));
      for (int j = 0; j < WIN; j++)
        cov_depth[j] = (j + shift < WIN) ? cov_depth[j + shift] : 32'd0;
      cov_base = s;
    end
    lo = longint'(s - cov_base);
    hi = longint'(e - cov_base);
    for (longint j = lo; j <= hi && j < WIN; j++) begin
      sum = longint'(cov_depth[j]) + longint'(w);
      cov_depth[j] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    end
    return ST_OK;
  endfunction

  // Work out the result of one accepted item.
  function automatic result_t predict_coverage(logic [1:0] rq, logic [31:0] s,
      logic [31:0] e, logic [15:0] rc, logic [31:0] len, logic [7:0] bi);
    result_t r;
    r.status = ST_OK;
    r.bin_count = '0;
    if (rq == REQ_ADD) begin
      r.status = add_coverage(s, e, cov_weighted ? {16'd0, rc} : 32'd1);
    end else if (rq == REQ_END) begin
      flush_window(WIN);
      if (len > cov_hits) cov_hist[0] = cov_hist[0] + COUNT_W'(len - cov_hits);
      cov_bases = cov_bases + COUNT_W'(len);
      foreach (cov_depth[j]) cov_depth[j] = '0;
      cov_base = '0;
      cov_hits = '0;
    end else if (rq == REQ_READ) begin
      r.bin_count = cov_hist[bi];
    end
    r.base_sum = cov_bases;
    r.aligned_reads = cov_reads;
    return r;
  endfunction

  // Send one item and record its expected result once it is accepted.
  task automatic send_item(logic [1:0] rq, logic [31:0] s, logic [31:0] e,
                           logic [15:0] rc, logic [31:0] len, logic [7:0] bi);
    if (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    start_pos <= s;
    end_pos <= e;
    repeat_count <= rc;
    subject_length <= len;
    bin_index <= bi;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_coverage(rq, s, e, rc, len, bi));
  endtask

  task automatic read_bin(logic [7:0] bi);
    send_item(REQ_READ, $urandom, $urandom, 16'($urandom), $urandom, bi);
  endtask

  task automatic add_read(logic [31:0] s, logic [31:0] e, logic [15:0] rc);
    send_item(REQ_ADD, s, e, rc, $urandom, 8'($urandom));
  endtask

  task automatic end_subject(logic [31:0] len);
    send_item(REQ_END, $urandom, $urandom, 16'($urandom), len, 8'($urandom));
  endtask

  // Write the weighting register once every result is back.
  task automatic set_weighting(logic v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cov_weighted = v;
  endtask

  task automatic test_empty_reads;
    read_bin(8'd0);
    read_bin(8'd255);
    send_item(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
  endtask

  task automatic test_rejects;
    add_read(32'd0, 32'd0, 16'd1);
    add_read(32'd10, 32'd5, 16'd1);
    add_read(32'd0, 32'd2048, 16'd1);
    add_read(32'hFFFF_F000, 32'hFFFF_FFFF, 16'd1);
    add_read(32'hFFFF_F800, 32'hFFFF_FFFF, 16'hFFFF);
    add_read(32'd100, 32'd200, 16'd1);
    end_subject(32'd5);
    read_bin(8'd1);
  endtask

  task automatic test_weighting;
    set_weighting(1'b1);
    add_read(32'd0, 32'd9, 16'hFFFF);
    add_read(32'd5, 32'd20, 16'd0);
    add_read(32'd5, 32'd6, 16'd300);
    add_read(32'd3000, 32'd3100, 16'd2);
    add_read(32'd10, 32'd12, 16'd1);
    end_subject(32'hFFFF_FFFF);
    read_bin(8'd255);
    read_bin(8'd0);
    read_bin(8'd2);
    end_subject(32'd0);
    set_weighting(1'b0);
  endtask

  // Mostly ordered reads of a subject, with noise and broken items mixed in.
  task automatic test_random_subjects(int n);
    int r;
    logic [31:0] s, e;
    cursor = $urandom_range(0, 5000);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70 || r > 96) begin
        s = cursor + $urandom_range(0, 20);
        e = s + (($urandom_range(0, 19) == 0) ? $urandom_range(0, 2047)
                                                : $urandom_range(0, 199));
        cursor = s;
        add_read(s, e, 16'($urandom));
      end else if (r < 73) begin
        s = cursor + $urandom_range(2048, 100000);
        cursor = s;
        add_read(s, s + $urandom_range(0, 300), 16'($urandom));
      end else if (r < 78) begin
        s = (cov_base > 0) ? cov_base - $urandom_range(1, 50) : cursor;
        add_read(s, s + 5, 16'($urandom));
      end else if (r < 81) begin
        s = cursor;
        e = $urandom_range(0, 1) ? s + 2048 + $urandom_range(0, 1000)
                                 : s - $urandom_range(1, 50);
        add_read(s, e, 16'($urandom));
      end else if (r < 91) begin
        read_bin(8'($urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(0, 255)));
      end else if (r < 94) begin
        send_item(REQ_UNKNOWN, $urandom, $urandom, 16'($urandom), $urandom, 8'($urandom));
      end else begin
        end_subject($urandom_range(0, 1) ? cursor + $urandom_range(0, 5000) : $urandom);
        cursor = $urandom_range(0, 1) ? $urandom_range(0, 5000)
                                      : $urandom_range(0, 32'hFFF0_0000);
      end
    end
  endtask

  // Result checker and receiver-side stall.
  always @(posedge clk) begin
    result_t x;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item");
        failed = 1'b1;
      end else begin
        x = pending_results.pop_front();
        if (status !== x.status) begin
          $error("status exp %0d got %0d", x.status, status);
          failed = 1'b1;
        end
        if (bin_count !== x.bin_count) begin
          $error("bin_count exp %0d got %0d", x.bin_count, bin_count);
          failed = 1'b1;
        end
        if (base_sum !== x.base_sum) begin
          $error("base_sum exp %0d got %0d", x.base_sum, base_sum);
          failed = 1'b1;
        end
        if (aligned_reads !== x.aligned_reads) begin
          $error("aligned_reads exp %0d got %0d", x.aligned_reads, aligned_reads);
          failed = 1'b1;
        end
      end
    end
    out_stall <= !calm && ($urandom_range(0, 99) < 8);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= 1'b0;
    in_valid <= 1'b0;
    req_type <= '0;
    start_pos <= '0;
    end_pos <= '0;
    repeat_count <= '0;
    subject_length <= '0;
    bin_index <= '0;
    foreach (cov_depth[j]) cov_depth[j] = '0;
    foreach (cov_hist[j]) cov_hist[j] = '0;
    cov_base = '0;
    cov_hits = '0;
    cov_bases = '0;
    cov_reads = '0;
    cov_weighted = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_empty_reads;
    test_rejects;
    test_weighting;
    test_random_subjects(350);
    set_weighting(1'b1);
    calm = 1'b1;
    test_random_subjects(350);
    calm = 1'b0;
    set_weighting(1'b0);
    test_random_subjects(350);
    set_weighting(1'b1);
    test_random_subjects(350);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/sdh_pkg.sv
rtl/sdh_cell.sv
rtl/sdh_hist.sv
rtl/sequencing_depth_histogram_top.sv
rtl/sdh_checker.sv
dv/tb.sv
